>>> hw/rtl/ptta_pkg.sv
// Types and constants shared by the proximity tag table.
`default_nettype none

package ptta_pkg;

  // One request as it arrives on the command port
  typedef struct packed {
    logic              req_type;
    logic [47:0]       tag_address;
    logic signed [7:0] signal_strength;
    logic [23:0]       now_ticks;
  } request_t;

  // One result as it leaves on the strobe port
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [47:0] entry_address;
    logic [3:0]  slot_index;
    logic [4:0]  occupied_count;
    logic        last_of_run;
  } result_t;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  strength;
    logic [23:0] seen_time;
  } slot_entry_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  localparam logic REQ_SIGHTING = 1'b0;
  localparam logic REQ_SWEEP    = 1'b1;

  localparam logic [2:0] EV_UPDATED = 3'd0;
  localparam logic [2:0] EV_ADDED   = 3'd1;
  localparam logic [2:0] EV_FULL    = 3'd2;
  localparam logic [2:0] EV_REMOVED = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;

  // Register select is paddr bit 2 (word 0 and word 1)
  localparam int          APB_ADDR_W  = 3;
  localparam logic        REG_TIMEOUT = 1'b0;
  localparam logic        REG_LIMIT   = 1'b1;

  localparam logic [23:0] TIMEOUT_RESET = 24'd32768;
  localparam logic [7:0]  LIMIT_RESET   = 8'd55;

endpackage

`default_nettype wire

>>> hw/rtl/proximity_tag_table_aging.sv
// Proximity tag table with aging: lookup, insert and sweep over a slot memory.
`default_nettype none

// Usage
// -----
// A request is taken at a rising edge with start high and busy low; busy then
// stays high until the request's last result has been shown. Every result is
// shown for exactly one cycle with result_valid high and cannot be held off,
// so the receiver must take it in that cycle. result.last_of_run marks the
// final result of a request, and busy is already low in that cycle, so a new
// request may be started there.
// Timing: the sequencer walks the slot memory one slot per cycle, the read of
// slot k+1 overlapping the check of slot k in the shared compare unit (address
// compare, 24-bit age subtract and compare, strength magnitude compare).
// A sighting that hits ends the walk at that slot; a sighting that misses and
// every sweep check all TABLE_ENTRIES slots before the last result.
// Sweep removals come out at most one per cycle, in slot order, as the walk finds
// them; the done result follows the walk. A full table drops the sighting.
// Configuration (APB, pready always high): byte address 0 presence_timeout
// (24 bit), byte address 4 strength_limit (8 bit). Only paddr bit 2 selects
// the register. Write only while busy is low. The valid flags are flip-flops
// cleared by reset, so there is no memory clearing pass; slot contents need
// no reset.

module proximity_tag_table_aging #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request port
  input  wire logic                        start,
  output      logic                        busy,
  input  wire ptta_pkg::request_t          request,
  // result port
  output      logic                        result_valid,
  output      ptta_pkg::result_t           result,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ptta_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);
  import ptta_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TABLE_ENTRIES);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t                   state, state_next;
  request_t                 req_q;
  logic [23:0]              timeout_q;
  logic [7:0]               limit_q;

  logic [PTR_W-1:0]         walk_idx;      // next slot to read
  logic                     chk_vld;       // rd_data holds slot chk_idx
  logic [IDX_W-1:0]         chk_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [PTR_W-1:0]         count;

  slot_entry_t              slot_mem [TABLE_ENTRIES];
  slot_entry_t              rd_data;

  // ---------------------------------------------------------------------------
  // Shared check unit: looks at the one slot just read
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        walk_rd;
  logic        chk_live;
  logic        addr_match;
  logic [23:0] age;
  logic        stale;
  logic [7:0]  abs_strength;
  logic        far;
  logic        hit;
  logic        expire;
  logic        finish;

  assign accept       = start && (state == ST_IDLE);
  assign walk_rd      = (state == ST_WALK) && (walk_idx != LAST_PTR);
  assign chk_live     = slot_valid[chk_idx];
  assign addr_match   = (rd_data.address == req_q.tag_address);
  // age wraps at 24 bits
  assign age          = req_q.now_ticks - rd_data.seen_time;
  assign stale        = (age > timeout_q);
  // -128 gives 8'h80, i.e. 128 read unsigned
  assign abs_strength = rd_data.strength[7] ? (~rd_data.strength + 8'd1)
                                            : rd_data.strength;
  assign far          = (abs_strength > limit_q);

  assign hit    = (state == ST_WALK) && chk_vld && (req_q.req_type == REQ_SIGHTING)
                  && chk_live && addr_match;
  assign expire = (state == ST_WALK) && chk_vld && (req_q.req_type == REQ_SWEEP)
                  && chk_live && (stale || far);
  // walk exhausted and the last slot checked without a hit
  assign finish = (state == ST_WALK) && !chk_vld && (walk_idx == LAST_PTR);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (hit || finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and table actions
  // ---------------------------------------------------------------------------
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_widx;
  slot_entry_t              mem_wdata;
  logic [TABLE_ENTRIES-1:0] slot_valid_next;
  logic [PTR_W-1:0]         count_next;
  logic                     result_valid_next;
  result_t                  result_next;

  always_comb begin
    busy              = (state != ST_IDLE);
    mem_we            = 1'b0;
    mem_widx          = chk_idx;
    mem_wdata         = '{address:   req_q.tag_address,
                          strength:  req_q.signal_strength,
                          seen_time: req_q.now_ticks};
    slot_valid_next   = slot_valid;
    count_next        = count;
    result_valid_next = 1'b0;
    result_next       = '{event_kind:     EV_DONE,
                          entry_address:  '0,
                          slot_index:     '0,
                          occupied_count: 5'(count),
                          last_of_run:    1'b1};
    priority if (hit) begin
      // refresh strength and time in place
      mem_we                     = 1'b1;
      result_valid_next          = 1'b1;
      result_next.event_kind     = EV_UPDATED;
      result_next.entry_address  = req_q.tag_address;
      result_next.slot_index     = 4'(chk_idx);
    end else if (expire) begin
      slot_valid_next[chk_idx]   = 1'b0;
      count_next                 = count - 1'b1;
      result_valid_next          = 1'b1;
      result_next.event_kind     = EV_REMOVED;
      result_next.entry_address  = rd_data.address;
      result_next.slot_index     = 4'(chk_idx);
      result_next.occupied_count = 5'(count_next);
      result_next.last_of_run    = 1'b0;
    end else if (finish) begin
      result_valid_next = 1'b1;
      if (req_q.req_type == REQ_SIGHTING) begin
        result_next.entry_address = req_q.tag_address;
        if (free_found) begin
          mem_we                     = 1'b1;
          mem_widx                   = free_idx;
          slot_valid_next[free_idx]  = 1'b1;
          count_next                 = count + 1'b1;
          result_next.event_kind     = EV_ADDED;
          result_next.slot_index     = 4'(free_idx);
          result_next.occupied_count = 5'(count_next);
        end else begin
          result_next.event_kind = EV_FULL;
        end
      end
    end else begin
      result_valid_next = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      walk_idx     <= '0;
      chk_vld      <= 1'b0;
      free_found   <= 1'b0;
      slot_valid   <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      slot_valid   <= slot_valid_next;
      count        <= count_next;
      result_valid <= result_valid_next;
      if (accept) begin
        walk_idx   <= '0;
        chk_vld    <= 1'b0;
        free_found <= 1'b0;
      end else if (state == ST_WALK) begin
        chk_vld <= walk_rd;
        if (walk_rd) walk_idx <= walk_idx + 1'b1;
        // remember the lowest empty slot seen
        if (chk_vld && !chk_live && !free_found) free_found <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) req_q <= request;
    if (walk_rd) chk_idx <= walk_idx[IDX_W-1:0];
    if ((state == ST_WALK) && chk_vld && !chk_live && !free_found) free_idx <= chk_idx;
    result <= result_next;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_widx] <= mem_wdata;
    if (walk_rd) rd_data <= slot_mem[walk_idx[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_q <= TIMEOUT_RESET;
      limit_q   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_TIMEOUT: timeout_q <= pwdata[23:0];
        REG_LIMIT:   limit_q   <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT: prdata = {8'd0, timeout_q};
      REG_LIMIT:   prdata = {24'd0, limit_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    count == PTR_W'($countones(slot_valid)))
    else $error("occupancy count out of step with valid flags");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= LAST_PTR)
    else $error("occupancy count above table size");

  a_last_frees_port: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_run |-> !busy)
    else $error("still busy on last result of a request");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_of_run |-> busy)
    else $error("removal shown with sequencer idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but sequencer not started");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.event_kind <= EV_DONE)
    else $error("undefined event kind");

endmodule

`default_nettype wire
